// ----- rtl/ssr_pkg.sv -----
// Shared types and codes for the subset-sum reachability core.
// Beat structs, action codes and the RAM control struct; no dependencies.
package ssr_pkg;

    localparam int VALUE_W = 13;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [VALUE_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic reachable;
        logic too_large;
    } t_out_beat;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_ram_ctl;

endpackage

// ----- rtl/subset_sum_reachability_core.sv -----
// Subset-sum reachability: the row of reachable sums lives in a word RAM.
// Input beat to result beat: query DIV, QREAD, QCHECK; add DIV, PRIME, LOAD, WALK (the RAM
// walk writes one word a cycle, high to low); clear SWEEP; all end in RESULT; zero,
// oversized, unused and out-of-range items RESULT only. Throughput: one item at a time; the
// next input beat is taken the cycle after the result is registered. WORD_BITS must be a
// power of two. Reset (sync, active low) sweeps the row to sum zero only, stalling input.
module subset_sum_reachability_core
    import ssr_pkg::*;
#(
    parameter int unsigned MAX_SUM   = 4096,
    parameter int unsigned WORD_BITS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int NWORDS = MAX_SUM / WORD_BITS + 1;
    localparam int AW     = $clog2(NWORDS);
    localparam int BW     = $clog2(WORD_BITS);
    localparam int TOP_BIT = MAX_SUM % WORD_BITS;
    localparam logic [AW-1:0] TOP_ADDR = AW'(NWORDS - 1);
    // keep only sums up to MAX_SUM in the top word
    localparam logic [WORD_BITS-1:0] TOP_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - 1 - TOP_BIT);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SWEEP  = 9'b000000010,
        ST_DIV    = 9'b000000100,
        ST_QREAD  = 9'b000001000,
        ST_QCHECK = 9'b000010000,
        ST_PRIME  = 9'b000100000,
        ST_LOAD   = 9'b001000000,
        ST_WALK   = 9'b010000000,
        ST_RESULT = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    logic [1:0]           r_act, n_act;
    logic [AW-1:0]        r_q, n_q;        // word offset of the shift
    logic [BW-1:0]        r_r, n_r;        // bit offset of the shift
    logic [AW-1:0]        r_d, n_d;        // word being swept or written
    logic [WORD_BITS-1:0] r_src_hi, n_src_hi;
    logic                 r_reach, n_reach;
    logic                 r_big, n_big;
    logic                 r_sweep_reply, n_sweep_reply;
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out_data, n_out_data;

    t_ram_ctl             ram_ctl;
    logic [AW-1:0]        rd_addr_a, rd_addr_b, wr_addr;
    logic [WORD_BITS-1:0] wr_data, rd_data_a, rd_data_b;

    logic                 div_start, div_done;
    logic [VALUE_W-1:0]   div_quot;
    logic [BW-1:0]        div_rem;

    logic                 in_accept;
    logic                 value_big;
    logic [WORD_BITS-1:0] src_lo;
    logic [WORD_BITS-1:0] lo_part;
    logic [BW:0]          lo_shamt;
    logic [WORD_BITS-1:0] walk_word;

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign value_big = 32'(i_in_data.value) > MAX_SUM;

    // Source words come in high to low: the low source of word d is the
    // high source of word d - 1. At the bottom word of the walk it is empty.
    assign src_lo   = (r_d != r_q) ? rd_data_b : '0;
    assign lo_shamt = (BW + 1)'(WORD_BITS) - {1'b0, r_r};
    assign lo_part  = (r_r == '0) ? '0 : (src_lo >> lo_shamt);
    assign walk_word = (rd_data_a | (r_src_hi << r_r) | lo_part)
                     & ((r_d == TOP_ADDR) ? TOP_MASK : {WORD_BITS{1'b1}});

    always_comb begin
        n_state       = r_state;
        n_act         = r_act;
        n_q           = r_q;
        n_r           = r_r;
        n_d           = r_d;
        n_src_hi      = r_src_hi;
        n_reach       = r_reach;
        n_big         = r_big;
        n_sweep_reply = r_sweep_reply;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;
        ram_ctl       = '0;
        rd_addr_a     = r_d;
        rd_addr_b     = r_d - r_q - 1'b1;
        wr_addr       = r_d;
        wr_data       = walk_word;
        div_start     = 1'b0;

        // drop the output beat once the sink takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_act   = i_in_data.action;
                    n_reach = 1'b0;
                    n_big   = 1'b0;
                    case (i_in_data.action)
                        ACT_CLEAR: begin
                            n_state       = ST_SWEEP;
                            n_d           = '0;
                            n_sweep_reply = 1'b1;
                        end
                        ACT_ADD: begin
                            if (value_big) begin
                                n_big   = 1'b1;
                                n_state = ST_RESULT;
                            end else if (i_in_data.value == '0) begin
                                n_state = ST_RESULT;
                            end else begin
                                div_start = 1'b1;
                                n_state   = ST_DIV;
                            end
                        end
                        ACT_QUERY: begin
                            if (value_big) begin
                                n_state = ST_RESULT;
                            end else begin
                                div_start = 1'b1;
                                n_state   = ST_DIV;
                            end
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // write the empty row, sum zero only
                ram_ctl.wr_en = 1'b1;
                wr_data       = WORD_BITS'(r_d == '0);
                if (r_d == TOP_ADDR) begin
                    n_state       = r_sweep_reply ? ST_RESULT : ST_IDLE;
                    n_sweep_reply = 1'b0;
                end else begin
                    n_d = r_d + 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_q     = AW'(div_quot);
                    n_r     = div_rem;
                    n_state = (r_act == ACT_QUERY) ? ST_QREAD : ST_PRIME;
                end
            end
            ST_QREAD: begin
                ram_ctl.rd_en = 1'b1;
                rd_addr_a     = r_q;
                n_state       = ST_QCHECK;
            end
            ST_QCHECK: begin
                n_reach = rd_data_a[r_r];
                n_state = ST_RESULT;
            end
            ST_PRIME: begin
                // fetch the high source of the top word
                ram_ctl.rd_en = 1'b1;
                rd_addr_b     = TOP_ADDR - r_q;
                n_d           = TOP_ADDR;
                n_state       = ST_LOAD;
            end
            ST_LOAD: begin
                ram_ctl.rd_en = 1'b1;
                n_src_hi      = rd_data_b;
                n_state       = ST_WALK;
            end
            ST_WALK: begin
                // write word d, fetch word d - 1 and its low source
                ram_ctl.wr_en = 1'b1;
                n_src_hi      = src_lo;
                if (r_d == r_q) begin
                    n_state = ST_RESULT;
                end else begin
                    ram_ctl.rd_en = 1'b1;
                    rd_addr_a     = r_d - 1'b1;
                    rd_addr_b     = r_d - r_q - 2'd2;
                    n_d           = r_d - 1'b1;
                end
            end
            ST_RESULT: begin
                // hold the beat until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid          = 1'b1;
                    n_out_data.reachable = r_reach;
                    n_out_data.too_large = r_big;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SWEEP;
            r_d           <= '0;
            r_sweep_reply <= 1'b0;
            r_out_valid   <= 1'b0;
            r_act         <= ACT_CLEAR;
        end else begin
            r_state       <= n_state;
            r_d           <= n_d;
            r_sweep_reply <= n_sweep_reply;
            r_out_valid   <= n_out_valid;
            r_act         <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q        <= n_q;
        r_r        <= n_r;
        r_src_hi   <= n_src_hi;
        r_reach    <= n_reach;
        r_big      <= n_big;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    ssr_const_div #(
        .DIVISOR (WORD_BITS),
        .BW      (BW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_value (i_in_data.value),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    ssr_row_ram #(
        .WORD_BITS (WORD_BITS),
        .NWORDS    (NWORDS),
        .AW        (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_ctl       (ram_ctl),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_d >= r_q))
        else $error("walk went below the shift word offset");

    a_top_word_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_ctl.wr_en && (wr_addr == TOP_ADDR)) |-> ((wr_data & ~TOP_MASK) == '0))
        else $error("sum above the limit written to the top word");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.too_large) |-> !o_out_data.reachable)
        else $error("beat flags both too large and reachable");

endmodule

// ----- rtl/ssr_row_ram.sv -----
// Row storage: one write port, two registered read ports.
// Depends on ssr_pkg for the control struct.
module ssr_row_ram
    import ssr_pkg::*;
#(
    parameter int WORD_BITS = 64,
    parameter int NWORDS    = 65,
    parameter int AW        = 7
) (
    input  logic                 i_clk,
    input  t_ram_ctl             i_ctl,
    input  logic [AW-1:0]        i_rd_addr_a,
    input  logic [AW-1:0]        i_rd_addr_b,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data,
    output logic [WORD_BITS-1:0] o_rd_data_a,
    output logic [WORD_BITS-1:0] o_rd_data_b
);

    logic [WORD_BITS-1:0] r_mem [NWORDS];
    logic [WORD_BITS-1:0] r_rd_a;
    logic [WORD_BITS-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ----- rtl/ssr_const_div.sv -----
// Word index and bit offset of a sum: divide by a power-of-two word width.
// A shift and a mask, registered once; depends on ssr_pkg for the value width.
module ssr_const_div
    import ssr_pkg::*;
#(
    parameter int DIVISOR = 64,
    parameter int BW      = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_done,
    output logic [VALUE_W-1:0] o_quot,
    output logic [BW-1:0]      o_rem
);

    localparam int SHIFT = $clog2(DIVISOR);
    localparam logic [VALUE_W-1:0] MASK = VALUE_W'(DIVISOR - 1);

    logic               r_done;
    logic [VALUE_W-1:0] r_quot;
    logic [BW-1:0]      r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // word index from the high bits, bit offset from the low bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_value >> SHIFT;
            r_rem  <= BW'(i_value & MASK);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule
